// ===== hw/rtl/iirlp4_pkg.sv =====
`default_nettype none

package iirlp4_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 18;
   localparam int COEF_FRAC_BITS = 16;
   localparam int HIST_FRAC      = 8;
   localparam int HIST_BITS      = SAMPLE_BITS + HIST_FRAC;
   localparam int HIST_DEPTH     = 4;
   localparam int SUM_BITS       = SAMPLE_BITS + 1;
   localparam int OPND_BITS      = SUM_BITS + HIST_FRAC;
   localparam int PROD_BITS      = COEF_BITS + OPND_BITS;
   localparam int ACC_BITS       = 48;
   localparam int SHIFT_BITS     = ACC_BITS - COEF_FRAC_BITS;
   localparam int NUM_REGS       = 7;
   localparam int CSR_IDX_BITS   = 3;

   // register indexes, also the order of taps through the multiplier
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_B0 = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_B1 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_B2 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_A1 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_A2 = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_A3 = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEF_A4 = 3'd6;
   // tap counter value after the last issue, waiting for the pipeline
   localparam logic [CSR_IDX_BITS-1:0] TAP_DRAIN   = 3'd7;

   localparam logic signed [COEF_BITS-1:0] RST_COEF_B0 = 18'sd1217;
   localparam logic signed [COEF_BITS-1:0] RST_COEF_B1 = 18'sd4866;
   localparam logic signed [COEF_BITS-1:0] RST_COEF_B2 = 18'sd7299;
   localparam logic signed [COEF_BITS-1:0] RST_COEF_A1 = -18'sd102919;
   localparam logic signed [COEF_BITS-1:0] RST_COEF_A2 = 18'sd83599;
   localparam logic signed [COEF_BITS-1:0] RST_COEF_A3 = -18'sd31746;
   localparam logic signed [COEF_BITS-1:0] RST_COEF_A4 = 18'sd4994;

   localparam logic signed [ACC_BITS-1:0] ACC_HALF =
      ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [HIST_BITS-1:0]   hist_type;
   typedef logic signed [OPND_BITS-1:0]   opnd_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;

   typedef struct packed {
      logic issue;
      logic subtract;
      logic clear;
   } mac_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/iirlp4_if.sv =====
`default_nettype none

interface iirlp4_req_if;
   import iirlp4_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface iirlp4_rsp_if;
   import iirlp4_pkg::*;

   logic       valid;
   logic       ready;
   sample_type filtered;
   logic       clipped;

   modport source (output valid, output filtered, output clipped, input ready);
   modport sink   (input valid, input filtered, input clipped, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/iirlp4_mac.sv =====
`default_nettype none

module iirlp4_mac (
   input  wire                       clock,
   input  wire                       reset,
   input  iirlp4_pkg::mac_ctrl_type  ctrl,
   input  iirlp4_pkg::coef_type      coef,
   input  iirlp4_pkg::opnd_type      operand,
   output iirlp4_pkg::acc_type       acc
);
   import iirlp4_pkg::*;

   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic                        prod_vld_ff;
   logic                        sub_ff;
   acc_type                     acc_ff;
   acc_type                     acc_in;
   acc_type                     prod_ext;

   assign prod_in  = coef * operand;
   assign prod_ext = ACC_BITS'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = sub_ff ? acc_ff - prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= ctrl.issue;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sub_ff  <= ctrl.subtract;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/iir_lowpass_order4_core.sv =====
// Fourth-order direct-form-I IIR low-pass filter on signed 16-bit words.
// req_chan carries one input sample per word; rsp_chan returns one filtered
// word (rounded, saturated to 16 bits) with a clipped flag for every sample.
// Both channels use valid/ready; a word moves when both are high.
// Coefficients b0, b1, b2, a1..a4 (Q2.16, already divided by a0) are written
// through csr_we/csr_index/csr_wdata; the user must write them only while the
// filter is idle, which the block does not enforce; index 7 is ignored.
// b0 also serves tap 4 and b1 tap 3. One 18x25 multiplier with an accumulator
// behind it is reused for all seven coefficient products, one per cycle, under
// a small sequencer. A sample's word reaches rsp_chan once the seven products
// are issued, the multiplier pipeline has drained and the history value and
// then the output value are rounded. req_chan.ready is high only while idle,
// so a new sample is taken only after the last one has left the sequencer.
// The result sits in an output register; the next sample is taken while it
// waits, but its own result is held back until rsp_chan has taken the old one.
// Reset loads the default coefficients and clears both histories.
`default_nettype none

module iir_lowpass_order4_core (
   input  wire                                   clock,
   input  wire                                   reset,
   iirlp4_req_if.sink                            req_chan,
   iirlp4_rsp_if.source                          rsp_chan,
   input  wire                                   csr_we,
   input  wire [iirlp4_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire [iirlp4_pkg::COEF_BITS-1:0]       csr_wdata
);
   import iirlp4_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MAC   = 4'b0010,
      ST_ROUND = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CSR_IDX_BITS-1:0]   tap_ff, tap_in;
   coef_type                  coef_ff [NUM_REGS];
   sample_type                sample_ff;
   sample_type                x_hist_ff [HIST_DEPTH];
   hist_type                  y_hist_ff [HIST_DEPTH];
   hist_type                  y8_ff, y8_in;
   logic                      hit_ff, hit_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sample_type                filtered_ff, filtered_in;
   logic                      clipped_ff;

   mac_ctrl_type              mac_ctrl;
   coef_type                  mac_coef;
   opnd_type                  mac_opnd;
   acc_type                   acc;

   logic                      accept;
   logic                      load_rsp;
   logic signed [SUM_BITS-1:0] fwd_sum;
   logic                      fwd_tap;
   acc_type                   acc_rnd;
   logic [SHIFT_BITS-1:0]     acc_shift;
   logic                      hist_ovf;
   logic [HIST_BITS:0]        y_rnd;
   logic [SUM_BITS-1:0]       r_int;
   logic                      out_ovf;

   assign accept   = req_chan.valid && req_chan.ready;
   assign load_rsp = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // operand select for the shared multiplier
   always_comb begin
      fwd_sum = '0;
      fwd_tap = 1'b1;
      mac_opnd = '0;
      case (tap_ff)
         CSR_COEF_B0: fwd_sum = SUM_BITS'(sample_ff) + SUM_BITS'(x_hist_ff[3]);
         CSR_COEF_B1: fwd_sum = SUM_BITS'(x_hist_ff[0]) + SUM_BITS'(x_hist_ff[2]);
         CSR_COEF_B2: fwd_sum = SUM_BITS'(x_hist_ff[1]);
         default:     fwd_tap = 1'b0;
      endcase
      case (tap_ff)
         CSR_COEF_A1: mac_opnd = OPND_BITS'(y_hist_ff[0]);
         CSR_COEF_A2: mac_opnd = OPND_BITS'(y_hist_ff[1]);
         CSR_COEF_A3: mac_opnd = OPND_BITS'(y_hist_ff[2]);
         CSR_COEF_A4: mac_opnd = OPND_BITS'(y_hist_ff[3]);
         default:     mac_opnd = $signed({fwd_sum, {HIST_FRAC{1'b0}}});
      endcase
      mac_coef = (tap_ff == TAP_DRAIN) ? '0 : coef_ff[tap_ff];
   end

   assign mac_ctrl.issue    = (state_ff == ST_MAC) && (tap_ff != TAP_DRAIN);
   assign mac_ctrl.subtract = !fwd_tap;
   assign mac_ctrl.clear    = accept;

   iirlp4_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .coef    (mac_coef),
      .operand (mac_opnd),
      .acc     (acc)
   );

   // round to Q.8 and saturate the history value
   always_comb begin
      acc_rnd   = acc + ACC_HALF;
      acc_shift = acc_rnd[ACC_BITS-1:COEF_FRAC_BITS];
      hist_ovf  = !((&acc_shift[SHIFT_BITS-1:HIST_BITS-1]) ||
                    (~|acc_shift[SHIFT_BITS-1:HIST_BITS-1]));
      if (hist_ovf) begin
         y8_in = acc_shift[SHIFT_BITS-1] ? {1'b1, {(HIST_BITS-1){1'b0}}}
                                         : {1'b0, {(HIST_BITS-1){1'b1}}};
      end else begin
         y8_in = acc_shift[HIST_BITS-1:0];
      end
   end

   // round the Q.8 value to an integer and saturate
   always_comb begin
      y_rnd   = {y8_ff[HIST_BITS-1], y8_ff} +
                ((HIST_BITS+1)'(1) << (HIST_FRAC - 1));
      r_int   = y_rnd[HIST_BITS:HIST_FRAC];
      out_ovf = r_int[SUM_BITS-1] ^ r_int[SUM_BITS-2];
      if (out_ovf) begin
         filtered_in = r_int[SUM_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
         filtered_in = r_int[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      hit_in   = hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MAC;
               tap_in   = '0;
            end
         end
         ST_MAC: begin
            tap_in = tap_ff + 1'b1;
            if (tap_ff == TAP_DRAIN) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            hit_in   = hist_ovf;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            x_hist_ff[i] <= '0;
            y_hist_ff[i] <= '0;
         end
         coef_ff[CSR_COEF_B0] <= RST_COEF_B0;
         coef_ff[CSR_COEF_B1] <= RST_COEF_B1;
         coef_ff[CSR_COEF_B2] <= RST_COEF_B2;
         coef_ff[CSR_COEF_A1] <= RST_COEF_A1;
         coef_ff[CSR_COEF_A2] <= RST_COEF_A2;
         coef_ff[CSR_COEF_A3] <= RST_COEF_A3;
         coef_ff[CSR_COEF_A4] <= RST_COEF_A4;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_ROUND) begin
            x_hist_ff[0] <= sample_ff;
            y_hist_ff[0] <= y8_in;
            for (int i = 1; i < HIST_DEPTH; i++) begin
               x_hist_ff[i] <= x_hist_ff[i-1];
               y_hist_ff[i] <= y_hist_ff[i-1];
            end
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_COEF_B0: coef_ff[CSR_COEF_B0] <= csr_wdata;
               CSR_COEF_B1: coef_ff[CSR_COEF_B1] <= csr_wdata;
               CSR_COEF_B2: coef_ff[CSR_COEF_B2] <= csr_wdata;
               CSR_COEF_A1: coef_ff[CSR_COEF_A1] <= csr_wdata;
               CSR_COEF_A2: coef_ff[CSR_COEF_A2] <= csr_wdata;
               CSR_COEF_A3: coef_ff[CSR_COEF_A3] <= csr_wdata;
               CSR_COEF_A4: coef_ff[CSR_COEF_A4] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      if (accept) begin
         sample_ff <= req_chan.sample;
      end
      if (state_ff == ST_ROUND) begin
         y8_ff <= y8_in;
      end
      if (load_rsp) begin
         filtered_ff <= filtered_in;
         clipped_ff  <= hit_ff || out_ovf;
      end
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.filtered = filtered_ff;
   assign rsp_chan.clipped  = clipped_ff;

endmodule

`default_nettype wire

// ===== verif/iir_lowpass_order4_core_test.sv =====
`timescale 1ns / 1ps

module iir_lowpass_order4_core_test;
   import iirlp4_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_IDX = 3'd7;
   localparam coef_type   COEF_MAX     = 18'sd131071;
   localparam coef_type   COEF_MIN     = -18'sd131072;
   localparam sample_type SAMPLE_MAX   = 16'sd32767;
   localparam sample_type SAMPLE_MIN   = -16'sd32768;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         LIMIT_CYCLES = 600000;
   localparam int         PRINT_CAP    = 40;

   typedef struct packed {
      sample_type filtered;
      logic       clipped;
   } filter_word_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [COEF_BITS-1:0]    csr_wdata = '0;

   iirlp4_req_if req_bus ();
   iirlp4_rsp_if rsp_bus ();

   iir_lowpass_order4_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state: coefficients and both histories
   coef_type   taps [NUM_REGS];
   sample_type x_hist [HIST_DEPTH];
   hist_type   y_hist [HIST_DEPTH];

   sample_type   sample_queue [$];
   filter_word_t due_words [$];
   sample_type   walk_level = '0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           mismatches = 0;
   int           cycle_count = 0;
   int           hold_left = 0;
   logic         hold_go = 1'b0;

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_CAP)
         $display("MISMATCH @%0t: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic void filter_predict(input sample_type x0, output filter_word_t word);
      longint fwd, back, acc, y8, r;
      logic   sat;
      sat = 1'b0;
      fwd = longint'(taps[CSR_COEF_B0]) * (longint'(x0) + longint'(x_hist[3]))
          + longint'(taps[CSR_COEF_B1]) * (longint'(x_hist[0]) + longint'(x_hist[2]))
          + longint'(taps[CSR_COEF_B2]) * longint'(x_hist[1]);
      back = longint'(taps[CSR_COEF_A1]) * longint'(y_hist[0])
           + longint'(taps[CSR_COEF_A2]) * longint'(y_hist[1])
           + longint'(taps[CSR_COEF_A3]) * longint'(y_hist[2])
           + longint'(taps[CSR_COEF_A4]) * longint'(y_hist[3]);
      // input part is Q.16, feedback part Q.24
      acc = (fwd <<< HIST_FRAC) - back + (longint'(1) <<< (COEF_FRAC_BITS - 1));
      y8 = acc >>> COEF_FRAC_BITS;
      if (y8 > (longint'(1) <<< (HIST_BITS - 1)) - 1) begin
         y8 = (longint'(1) <<< (HIST_BITS - 1)) - 1;
         sat = 1'b1;
      end else if (y8 < -(longint'(1) <<< (HIST_BITS - 1))) begin
         y8 = -(longint'(1) <<< (HIST_BITS - 1));
         sat = 1'b1;
      end
      r = (y8 + (longint'(1) <<< (HIST_FRAC - 1))) >>> HIST_FRAC;
      if (r > longint'(SAMPLE_MAX)) begin
         r = longint'(SAMPLE_MAX);
         sat = 1'b1;
      end else if (r < longint'(SAMPLE_MIN)) begin
         r = longint'(SAMPLE_MIN);
         sat = 1'b1;
      end
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
         x_hist[i] = x_hist[i-1];
         y_hist[i] = y_hist[i-1];
      end
      x_hist[0] = x0;
      y_hist[0] = hist_type'(y8);
      word.filtered = sample_type'(r);
      word.clipped = sat;
   endfunction

   task automatic write_coef(input logic [CSR_IDX_BITS-1:0] idx, input coef_type value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic queue_random(input int count);
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(3))
            0: walk_level = sample_type'($urandom);
            1: walk_level = sample_type'(int'($urandom_range(600)) - 300);
            2: walk_level = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            // random walk, wraps at the ends
            default: walk_level = walk_level + sample_type'(int'($urandom_range(2000)) - 1000);
         endcase
         sample_queue.push_back(walk_level);
      end
   endtask

   // looked at between edges, once the sender's pop and its valid agree
   task automatic wait_drained;
      do
         @(negedge clock);
      while (sample_queue.size() != 0 || due_words.size() != 0 || req_bus.valid);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid  <= 1'b1;
            req_bus.sample <= sample_queue.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // long hold-off on the result side
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_go)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // receiver
   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: check results first, then predict from accepted samples
   always @(posedge clock) begin
      filter_word_t got, want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.filtered = rsp_bus.filtered;
            got.clipped  = rsp_bus.clipped;
            if (due_words.size() == 0) begin
               report_mismatch($sformatf("word with nothing due: filtered %0d clipped %0b",
                                         got.filtered, got.clipped));
            end else begin
               want = due_words.pop_front();
               if (got.filtered !== want.filtered)
                  report_mismatch($sformatf("filtered %0d, want %0d",
                                            got.filtered, want.filtered));
               if (got.clipped !== want.clipped)
                  report_mismatch($sformatf("clipped %0b, want %0b (filtered %0d)",
                                            got.clipped, want.clipped, want.filtered));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            filter_predict(req_bus.sample, want);
            due_words.push_back(want);
         end
         if (csr_we && csr_index < NUM_REGS)
            taps[csr_index] = coef_type'(csr_wdata);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("iir_lowpass_order4_core verification failed");
         $finish;
      end
   end

   initial begin
      coef_type coef_set [NUM_REGS];
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      rsp_bus.ready  = 1'b0;
      taps[CSR_COEF_B0] = RST_COEF_B0;
      taps[CSR_COEF_B1] = RST_COEF_B1;
      taps[CSR_COEF_B2] = RST_COEF_B2;
      taps[CSR_COEF_A1] = RST_COEF_A1;
      taps[CSR_COEF_A2] = RST_COEF_A2;
      taps[CSR_COEF_A3] = RST_COEF_A3;
      taps[CSR_COEF_A4] = RST_COEF_A4;
      for (int i = 0; i < HIST_DEPTH; i++) begin
         x_hist[i] = '0;
         y_hist[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 8; phase++) begin
         if (phase < 3) begin
            send_idle_pct <= 25;
            recv_idle_pct <= 86;
         end else if (phase < 6) begin
            send_idle_pct <= 86;
            recv_idle_pct <= 25;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end

         // phase 0 runs on the reset coefficients
         if (phase != 0) begin
            for (int i = 0; i < NUM_REGS; i++) begin
               case (phase)
                  1: coef_set[i] = COEF_MAX;
                  2: coef_set[i] = COEF_MIN;
                  3: coef_set[i] = (i < CSR_COEF_A1) ?
                                   coef_type'(int'($urandom_range(40000)) - 20000) : '0;
                  5: coef_set[i] = '0;
                  6: coef_set[i] = (i < CSR_COEF_A1) ? COEF_MAX : '0;
                  default: coef_set[i] = coef_type'($urandom);
               endcase
            end
            if (phase == 5) begin
               coef_set[CSR_COEF_B0] = RST_COEF_B0;
               coef_set[CSR_COEF_B1] = RST_COEF_B1;
               coef_set[CSR_COEF_B2] = RST_COEF_B2;
               coef_set[CSR_COEF_A1] = RST_COEF_A1;
               coef_set[CSR_COEF_A2] = RST_COEF_A2;
               coef_set[CSR_COEF_A3] = RST_COEF_A3;
               coef_set[CSR_COEF_A4] = RST_COEF_A4;
            end
            for (int i = 0; i < NUM_REGS; i++)
               write_coef(CSR_IDX_BITS'(i), coef_set[i]);
            // the spare index must leave every tap alone
            if (phase == 1 || phase == 5)
               write_coef(CSR_UNUSED_IDX, phase == 1 ? COEF_MIN : COEF_MAX);
         end

         if (phase == 0) begin
            sample_queue.push_back('0);
            sample_queue.push_back(16'sd1);
            sample_queue.push_back(-16'sd1);
            sample_queue.push_back(SAMPLE_MAX);
            sample_queue.push_back(SAMPLE_MIN);
            sample_queue.push_back(16'sh5555);
            sample_queue.push_back(16'shAAAA);
            // full-scale step overshoots and clips
            repeat (6) sample_queue.push_back(SAMPLE_MIN);
            repeat (10) sample_queue.push_back(SAMPLE_MAX);
         end
         queue_random(225);

         if (phase == 7) begin
            @(posedge clock);
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         wait_drained();
      end

      repeat (24) @(posedge clock);
      if (mismatches == 0)
         $display("iir_lowpass_order4_core verification clean");
      else
         $display("iir_lowpass_order4_core verification failed");
      $finish;
   end

endmodule
